/* sv/k_nearest_distance_selector_unit_macros.svh */
// assertion macros for the k-nearest distance selector checker
`ifndef K_NEAREST_DISTANCE_SELECTOR_UNIT_MACROS_SVH
`define K_NEAREST_DISTANCE_SELECTOR_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define KNDSEL_ASSERT_SAME(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// consequent checked in the cycle after the antecedent
`define KNDSEL_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

/* sv/kndsel_pkg.sv */
// shared types and constants of the k-nearest distance selector
package kndsel_pkg;

    // fixed field widths
    localparam int DIST_W      = 32;
    localparam int CAND_ID_W   = 20;
    localparam int KEEP_W      = 6;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_BOUND = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_COUNT    = 1'b1;

    // configuration reset values
    localparam logic [DIST_W-1:0] INITIAL_BOUND_RST = 32'hFFFF_FFFF;
    localparam logic [KEEP_W-1:0] KEEP_COUNT_RST    = 6'd32;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_SCAN_END,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // compare stage control toward the max tracker
    typedef struct packed {
        logic sample;
        logic first;
    } scan_ctl_t;

endpackage

/* sv/kndsel_mem.sv */
// kept entry store: one write port, one read port with registered data
module kndsel_mem #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 52,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/kndsel_maxscan.sv */
// running maximum over a stream of read entries, lowest slot wins ties
module kndsel_maxscan #(
    parameter int ADDR_W = 5
) (
    input  logic                           clk,
    input  kndsel_pkg::scan_ctl_t          ctl,
    input  logic [ADDR_W-1:0]              idx,
    input  logic [kndsel_pkg::DIST_W-1:0]  rd_dist,
    output logic [kndsel_pkg::DIST_W-1:0]  best_dist,
    output logic [ADDR_W-1:0]              best_slot
);

    logic [kndsel_pkg::DIST_W-1:0] best_dist_reg;
    logic [ADDR_W-1:0]             best_slot_reg;

    // first entry loads, later ones replace only when strictly larger
    always_ff @(posedge clk)
    begin
        if (ctl.sample && (ctl.first || (rd_dist > best_dist_reg)))
        begin
            best_dist_reg <= rd_dist;
            best_slot_reg <= idx;
        end
    end

    assign best_dist = best_dist_reg;
    assign best_slot = best_slot_reg;

endmodule

/* sv/k_nearest_distance_selector_unit.sv */
// top level of the k-nearest distance selector: controller, bound and output stage
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  in      | input     | in_valid / in_stall  | cand_id, cand_dist, query_end
//  out     | output    | out_valid / out_stall| kept_id, kept_dist, final_bound, kept_total,
//          |           |                     | entry_valid, last_entry
//  cfg     | input     | cfg_wr_en           | cfg_index, cfg_data
//
//  a rejected candidate or a plain append is settled in ST_DECIDE; filling the store or replacing
//  the farthest entry adds a scan of the store through the one read port, twice when the
//  farthest slot is not yet known
//  a query end emits the kept entries one by one through the read port, waiting under out_stall
//  reset clears the fill count and loads the bound; the store is only read below the fill
//  the output register lets the next transaction in while the last result waits
module k_nearest_distance_selector_unit #(
    parameter int MAX_KEEP = 32,
    parameter int ID_BITS  = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [kndsel_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [kndsel_pkg::CFG_DATA_W-1:0]   cfg_data,
    // candidates
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [kndsel_pkg::CAND_ID_W-1:0]    cand_id,
    input  logic [kndsel_pkg::DIST_W-1:0]       cand_dist,
    input  logic                                query_end,
    // kept entries
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [kndsel_pkg::CAND_ID_W-1:0]    kept_id,
    output logic [kndsel_pkg::DIST_W-1:0]       kept_dist,
    output logic [kndsel_pkg::DIST_W-1:0]       final_bound,
    output logic [kndsel_pkg::KEEP_W-1:0]       kept_total,
    output logic                                entry_valid,
    output logic                                last_entry
);

    localparam int ADDR_W  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CNT_W   = $clog2(MAX_KEEP + 1);
    localparam int CMP_W   = (CNT_W > kndsel_pkg::KEEP_W) ? CNT_W : kndsel_pkg::KEEP_W;
    localparam int ID_W    = (ID_BITS < kndsel_pkg::CAND_ID_W) ? ID_BITS
                                                                : kndsel_pkg::CAND_ID_W;
    localparam int DIST_W  = kndsel_pkg::DIST_W;
    localparam int ENTRY_W = ID_W + DIST_W;
    localparam logic [CMP_W-1:0] MAX_KEEP_C = CMP_W'(MAX_KEEP);

    // control state
    kndsel_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [DIST_W-1:0]  bound_reg, bound_next;
    logic [DIST_W-1:0]  init_bound_reg, init_bound_next;
    logic [kndsel_pkg::KEEP_W-1:0] keep_count_reg, keep_count_next;
    logic [ADDR_W-1:0]  far_slot_reg, far_slot_next;
    logic               far_valid_reg, far_valid_next;
    logic               find_mode_reg, find_mode_next;
    logic [CNT_W-1:0]   issue_idx_reg, issue_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]   emit_idx_reg, emit_idx_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic [ID_W-1:0]    cand_id_reg, cand_id_next;
    logic [DIST_W-1:0]  cand_dist_reg, cand_dist_next;
    logic               cand_last_reg, cand_last_next;
    logic [kndsel_pkg::CAND_ID_W-1:0] kept_id_reg, kept_id_next;
    logic [DIST_W-1:0]  kept_dist_reg, kept_dist_next;
    logic [DIST_W-1:0]  final_bound_reg, final_bound_next;
    logic [kndsel_pkg::KEEP_W-1:0] kept_total_reg, kept_total_next;
    logic               entry_valid_reg, entry_valid_next;
    logic               last_entry_reg, last_entry_next;

    // memory and scan connections
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;
    logic [DIST_W-1:0]  best_dist;
    logic [ADDR_W-1:0]  best_slot;
    kndsel_pkg::scan_ctl_t scan_ctl;

    // decision terms
    logic               in_accept;
    logic               out_free;
    logic [CMP_W-1:0]   fill_ext;
    logic [CMP_W-1:0]   keep_ext;
    logic [CMP_W-1:0]   n_eff;
    logic               cand_ok;
    logic               not_full;
    logic               reaches_full;
    logic               issue;
    logic               scan_done;
    logic               emit_last;
    logic               fill_zero;
    kndsel_pkg::state_t done_state;

    assign in_accept    = in_valid && !in_stall;
    assign in_stall     = (state_reg != kndsel_pkg::ST_IDLE);
    assign out_free     = !out_valid_reg || !out_stall;
    assign fill_ext     = CMP_W'(fill_reg);
    assign keep_ext     = CMP_W'(keep_count_reg);
    assign n_eff        = (keep_ext == '0) ? CMP_W'(1)
                        : ((keep_ext > MAX_KEEP_C) ? MAX_KEEP_C : keep_ext);
    assign cand_ok      = (cand_dist_reg <= bound_reg);
    assign not_full     = (fill_ext < n_eff);
    assign reaches_full = (CMP_W'(fill_ext + CMP_W'(1)) == n_eff);
    assign issue        = (state_reg == kndsel_pkg::ST_SCAN) && (issue_idx_reg < fill_reg);
    assign scan_done    = !issue && !cmp_valid_reg;
    assign fill_zero    = (fill_reg == '0);
    assign emit_last    = fill_zero || (CNT_W'(emit_idx_reg + 1'b1) == fill_reg);
    assign done_state   = cand_last_reg ? kndsel_pkg::ST_EMIT_RD : kndsel_pkg::ST_IDLE;

    assign scan_ctl.sample = cmp_valid_reg;
    assign scan_ctl.first  = (cmp_idx_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kndsel_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = kndsel_pkg::ST_DECIDE;
                end
            end
            kndsel_pkg::ST_DECIDE:
            begin
                if (cand_ok && (!not_full || reaches_full))
                begin
                    state_next = kndsel_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = done_state;
                end
            end
            kndsel_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = kndsel_pkg::ST_SCAN_END;
                end
            end
            kndsel_pkg::ST_SCAN_END:
            begin
                state_next = find_mode_reg ? kndsel_pkg::ST_SCAN : done_state;
            end
            kndsel_pkg::ST_EMIT_RD:
            begin
                state_next = kndsel_pkg::ST_EMIT_LD;
            end
            kndsel_pkg::ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? kndsel_pkg::ST_IDLE : kndsel_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = kndsel_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        fill_next        = fill_reg;
        bound_next       = bound_reg;
        init_bound_next  = init_bound_reg;
        keep_count_next  = keep_count_reg;
        far_slot_next    = far_slot_reg;
        far_valid_next   = far_valid_reg;
        find_mode_next   = find_mode_reg;
        issue_idx_next   = issue_idx_reg;
        cmp_valid_next   = issue;
        cmp_idx_next     = issue_idx_reg[ADDR_W-1:0];
        emit_idx_next    = emit_idx_reg;
        out_valid_next   = out_valid_reg && out_stall;
        cand_id_next     = cand_id_reg;
        cand_dist_next   = cand_dist_reg;
        cand_last_next   = cand_last_reg;
        kept_id_next     = kept_id_reg;
        kept_dist_next   = kept_dist_reg;
        final_bound_next = final_bound_reg;
        kept_total_next  = kept_total_reg;
        entry_valid_next = entry_valid_reg;
        last_entry_next  = last_entry_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = fill_reg[ADDR_W-1:0];
        mem_rd_en        = 1'b0;
        mem_rd_addr      = issue_idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            kndsel_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    cand_id_next   = cand_id[ID_W-1:0];
                    cand_dist_next = cand_dist;
                    cand_last_next = query_end;
                end
            end
            kndsel_pkg::ST_DECIDE:
            begin
                issue_idx_next = '0;
                if (cand_ok)
                begin
                    if (not_full)
                    begin
                        // append at the fill position
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = fill_reg[ADDR_W-1:0];
                        fill_next      = CNT_W'(fill_reg + 1'b1);
                        far_valid_next = 1'b0;
                        find_mode_next = 1'b0;
                    end
                    else if (far_valid_reg)
                    begin
                        // farthest slot known from the last scan
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = far_slot_reg;
                        find_mode_next = 1'b0;
                    end
                    else
                    begin
                        find_mode_next = 1'b1;
                    end
                end
            end
            kndsel_pkg::ST_SCAN:
            begin
                mem_rd_en   = issue;
                mem_rd_addr = issue_idx_reg[ADDR_W-1:0];
                if (issue)
                begin
                    issue_idx_next = CNT_W'(issue_idx_reg + 1'b1);
                end
            end
            kndsel_pkg::ST_SCAN_END:
            begin
                issue_idx_next = '0;
                if (find_mode_reg)
                begin
                    // replace the farthest entry, then rescan for the new bound
                    mem_wr_en      = 1'b1;
                    mem_wr_addr    = best_slot;
                    find_mode_next = 1'b0;
                end
                else
                begin
                    bound_next     = best_dist;
                    far_slot_next  = best_slot;
                    far_valid_next = 1'b1;
                end
            end
            kndsel_pkg::ST_EMIT_RD:
            begin
                mem_rd_en   = !fill_zero;
                mem_rd_addr = emit_idx_reg[ADDR_W-1:0];
            end
            kndsel_pkg::ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    kept_id_next     = fill_zero ? '0
                                     : kndsel_pkg::CAND_ID_W'(mem_rd_data[ENTRY_W-1 -: ID_W]);
                    kept_dist_next   = fill_zero ? '0 : mem_rd_data[DIST_W-1:0];
                    final_bound_next = bound_reg;
                    kept_total_next  = kndsel_pkg::KEEP_W'(fill_reg);
                    entry_valid_next = !fill_zero;
                    last_entry_next  = emit_last;
                    if (emit_last)
                    begin
                        // query done, start the next one fresh
                        fill_next      = '0;
                        bound_next     = init_bound_reg;
                        far_valid_next = 1'b0;
                        emit_idx_next  = '0;
                    end
                    else
                    begin
                        emit_idx_next = CNT_W'(emit_idx_reg + 1'b1);
                    end
                end
            end
            default:
            begin
            end
        endcase

        // register writes
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                kndsel_pkg::REG_INITIAL_BOUND:
                begin
                    init_bound_next = cfg_data[DIST_W-1:0];
                    if (fill_zero)
                    begin
                        bound_next = cfg_data[DIST_W-1:0];
                    end
                end
                kndsel_pkg::REG_KEEP_COUNT:
                begin
                    keep_count_next = cfg_data[kndsel_pkg::KEEP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kndsel_pkg::ST_IDLE;
            fill_reg       <= '0;
            bound_reg      <= kndsel_pkg::INITIAL_BOUND_RST;
            init_bound_reg <= kndsel_pkg::INITIAL_BOUND_RST;
            keep_count_reg <= kndsel_pkg::KEEP_COUNT_RST;
            far_slot_reg   <= '0;
            far_valid_reg  <= 1'b0;
            find_mode_reg  <= 1'b0;
            issue_idx_reg  <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            bound_reg      <= bound_next;
            init_bound_reg <= init_bound_next;
            keep_count_reg <= keep_count_next;
            far_slot_reg   <= far_slot_next;
            far_valid_reg  <= far_valid_next;
            find_mode_reg  <= find_mode_next;
            issue_idx_reg  <= issue_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            cmp_idx_reg    <= cmp_idx_next;
            emit_idx_reg   <= emit_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cand_id_reg     <= cand_id_next;
        cand_dist_reg   <= cand_dist_next;
        cand_last_reg   <= cand_last_next;
        kept_id_reg     <= kept_id_next;
        kept_dist_reg   <= kept_dist_next;
        final_bound_reg <= final_bound_next;
        kept_total_reg  <= kept_total_next;
        entry_valid_reg <= entry_valid_next;
        last_entry_reg  <= last_entry_next;
    end

    // kept entry store
    kndsel_mem #(
        .DEPTH  (MAX_KEEP),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data ({cand_id_reg, cand_dist_reg}),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // farthest entry tracker
    kndsel_maxscan #(
        .ADDR_W (ADDR_W)
    ) u_maxscan (
        .clk       (clk),
        .ctl       (scan_ctl),
        .idx       (cmp_idx_reg),
        .rd_dist   (mem_rd_data[DIST_W-1:0]),
        .best_dist (best_dist),
        .best_slot (best_slot)
    );

    // outputs
    assign out_valid   = out_valid_reg;
    assign kept_id     = kept_id_reg;
    assign kept_dist   = kept_dist_reg;
    assign final_bound = final_bound_reg;
    assign kept_total  = kept_total_reg;
    assign entry_valid = entry_valid_reg;
    assign last_entry  = last_entry_reg;

endmodule

/* sv/kndsel_checker.sv */
// port-level checks of the k-nearest distance selector and their binding
`include "k_nearest_distance_selector_unit_macros.svh"

module kndsel_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [kndsel_pkg::DIST_W-1:0]   kept_dist,
    input logic [kndsel_pkg::DIST_W-1:0]   final_bound,
    input logic [kndsel_pkg::KEEP_W-1:0]   kept_total,
    input logic                            entry_valid,
    input logic                            last_entry
);

    // a stalled result stays put
    `KNDSEL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(kept_dist) && $stable(last_entry), "stalled result changed")

    // one candidate at a time: the input closes right after a transaction
    `KNDSEL_ASSERT_NEXT(a_in_closes, clk, rst_n, in_valid && !in_stall, in_stall, "input open after transaction")

    // an empty query shows as a single closing result with no entries
    `KNDSEL_ASSERT_SAME(a_empty_query, clk, rst_n, out_valid && !entry_valid, last_entry && (kept_total == '0), "malformed empty query result")

    // every kept entry lies within the final bound of its query
    `KNDSEL_ASSERT_SAME(a_within_bound, clk, rst_n, out_valid && entry_valid, (kept_total != '0) && (kept_dist <= final_bound), "kept entry beyond bound")

endmodule

bind k_nearest_distance_selector_unit kndsel_checker u_kndsel_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kept_dist   (kept_dist),
    .final_bound (final_bound),
    .kept_total  (kept_total),
    .entry_valid (entry_valid),
    .last_entry  (last_entry)
);

/* dv/tb.sv */
`timescale 1ns / 100ps
// testbench of the k-nearest distance selector: directed and random queries with a predictor
module tb;

    localparam int MAX_KEEP      = 32;
    localparam int SETTLE_CYCLES = 100;
    localparam int IDLE_PCT      = 34;

    // one emitted kept entry
    typedef struct {
        logic [kndsel_pkg::CAND_ID_W-1:0] id;
        logic [kndsel_pkg::DIST_W-1:0]    dist_sq;
        logic [kndsel_pkg::DIST_W-1:0]    bound;
        logic [kndsel_pkg::KEEP_W-1:0]    total;
        logic                             has_entry;
        logic                             closes_run;
    } kept_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_wr_en;
    logic [kndsel_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [kndsel_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                               in_valid;
    logic                               in_stall;
    logic [kndsel_pkg::CAND_ID_W-1:0]   cand_id;
    logic [kndsel_pkg::DIST_W-1:0]      cand_dist;
    logic                               query_end;
    logic                               out_valid;
    logic                               out_stall;
    logic [kndsel_pkg::CAND_ID_W-1:0]   kept_id;
    logic [kndsel_pkg::DIST_W-1:0]      kept_dist;
    logic [kndsel_pkg::DIST_W-1:0]      final_bound;
    logic [kndsel_pkg::KEEP_W-1:0]      kept_total;
    logic                               entry_valid;
    logic                               last_entry;

    // predictor state: kept candidates, current radius and register copies
    logic [kndsel_pkg::CAND_ID_W-1:0] held_id   [MAX_KEEP];
    logic [kndsel_pkg::DIST_W-1:0]    held_dist [MAX_KEEP];
    int unsigned                      held_count;
    logic [kndsel_pkg::DIST_W-1:0]    radius;
    logic [kndsel_pkg::DIST_W-1:0]    start_radius;
    logic [kndsel_pkg::KEEP_W-1:0]    keep_setting;
    kept_result_t                     expected_entries[$];
    int                               error_count;
    bit                               steady;

    k_nearest_distance_selector_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cand_id     (cand_id),
        .cand_dist   (cand_dist),
        .query_end   (query_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kept_id     (kept_id),
        .kept_dist   (kept_dist),
        .final_bound (final_bound),
        .kept_total  (kept_total),
        .entry_valid (entry_valid),
        .last_entry  (last_entry)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= rst_n && !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // effective keep count: zero acts as one, large values clamp
    function automatic int unsigned keep_limit();
        if (keep_setting == '0)
            return 1;
        if (keep_setting > MAX_KEEP)
            return MAX_KEEP;
        return keep_setting;
    endfunction

    // lowest slot holding the largest distance
    function automatic int unsigned farthest_slot();
        int unsigned best;
        best = 0;
        for (int unsigned i = 1; i < held_count && i < MAX_KEEP; i++)
            if (held_dist[i] > held_dist[best])
                best = i;
        return best;
    endfunction

    // update kept set with one candidate and queue the entries a query end releases
    function automatic void select_nearest(logic [kndsel_pkg::CAND_ID_W-1:0] id,
                                           logic [kndsel_pkg::DIST_W-1:0] cdist,
                                           logic last);
        int unsigned  limit;
        int unsigned  slot;
        kept_result_t r;
        limit = keep_limit();
        if (cdist <= radius)
        begin
            if (held_count < limit)
            begin
                held_id[held_count]   = id;
                held_dist[held_count] = cdist;
                held_count++;
                if (held_count == limit)
                    radius = held_dist[farthest_slot()];
            end
            else
            begin
                slot            = farthest_slot();
                held_id[slot]   = id;
                held_dist[slot] = cdist;
                radius          = held_dist[farthest_slot()];
            end
        end
        if (last)
        begin
            if (held_count == 0)
            begin
                r.id         = '0;
                r.dist_sq    = '0;
                r.bound      = radius;
                r.total      = '0;
                r.has_entry  = 1'b0;
                r.closes_run = 1'b1;
                expected_entries = {expected_entries, r};
            end
            else
            begin
                for (int unsigned i = 0; i < held_count; i++)
                begin
                    r.id         = held_id[i];
                    r.dist_sq    = held_dist[i];
                    r.bound      = radius;
                    r.total      = held_count[kndsel_pkg::KEEP_W-1:0];
                    r.has_entry  = 1'b1;
                    r.closes_run = (i + 1 == held_count);
                    expected_entries = {expected_entries, r};
                end
            end
            held_count = 0;
            radius     = start_radius;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // compare each kept transaction with the oldest expectation
    always @(posedge clk)
    begin
        kept_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_entries.size() == 0)
            begin
                $error("unexpected kept transaction: kept_id %0h, kept_dist %0h",
                       kept_id, kept_dist);
                error_count++;
            end
            else
            begin
                want = expected_entries.pop_front();
                check_field("kept_id", want.id, kept_id);
                check_field("kept_dist", want.dist_sq, kept_dist);
                check_field("final_bound", want.bound, final_bound);
                check_field("kept_total", want.total, kept_total);
                check_field("entry_valid", want.has_entry, entry_valid);
                check_field("last_entry", want.closes_run, last_entry);
            end
        end
    end

    // send one candidate; valid stays high afterwards until the next call or a settle
    task automatic push_candidate(logic [kndsel_pkg::CAND_ID_W-1:0] id,
                                  logic [kndsel_pkg::DIST_W-1:0] cdist, logic last);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        cand_id   <= id;
        cand_dist <= cdist;
        query_end <= last;
        do
            @(posedge clk);
        while (in_stall);
        select_nearest(id, cdist, last);
    endtask

    // stop sending, wait for every expected entry, then let internal work finish
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_entries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [kndsel_pkg::CFG_INDEX_W-1:0] index,
                                  logic [kndsel_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        if (index == kndsel_pkg::REG_INITIAL_BOUND)
        begin
            start_radius = value;
            if (held_count == 0)
                radius = value;
        end
        else
            keep_setting = value[kndsel_pkg::KEEP_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // distance mix: within bound, at bound, extremes, ties and raw noise
    function automatic logic [kndsel_pkg::DIST_W-1:0] pick_distance(
        logic [kndsel_pkg::DIST_W-1:0] bound);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(bound, 0);
            4:          return bound;
            5:          return '0;
            6:          return '1;
            7:          return bound >> 1;
            8:          return 32'd7;
            default:    return $urandom();
        endcase
    endfunction

    // reset values, field extremes on both ends
    task automatic test_default_query();
        push_candidate(20'h00000, 32'h0000_0000, 1'b0);
        push_candidate(20'hFFFFF, 32'hFFFF_FFFF, 1'b0);
        push_candidate(20'h5A5A5, 32'h5555_5555, 1'b0);
        push_candidate(20'hA5A5A, 32'hAAAA_AAAA, 1'b1);
    endtask

    // query that ends with nothing kept
    task automatic test_empty_query();
        settle_block();
        write_register(kndsel_pkg::REG_INITIAL_BOUND, 32'd1000);
        push_candidate(20'h12345, 32'd1001, 1'b1);
    endtask

    // candidate equal to bound accepted, ties replace the lowest slot
    task automatic test_equal_distances();
        settle_block();
        write_register(kndsel_pkg::REG_KEEP_COUNT, 32'd3);
        push_candidate(20'd1, 32'd1000, 1'b0);
        push_candidate(20'd2, 32'd500, 1'b0);
        push_candidate(20'd3, 32'd1000, 1'b0);
        push_candidate(20'd4, 32'd1000, 1'b0);
        push_candidate(20'd5, 32'd200, 1'b1);
    endtask

    // keep count zero acts as one
    task automatic test_single_keep();
        settle_block();
        write_register(kndsel_pkg::REG_INITIAL_BOUND, '1);
        write_register(kndsel_pkg::REG_KEEP_COUNT, 32'd0);
        push_candidate(20'd7, 32'd70, 1'b0);
        push_candidate(20'd8, 32'd90, 1'b0);
        push_candidate(20'd9, 32'd20, 1'b1);
    endtask

    // keep count lowered and bound rewritten while entries are held
    task automatic test_keep_lowered_mid_query();
        settle_block();
        write_register(kndsel_pkg::REG_KEEP_COUNT, 32'd8);
        for (int i = 0; i < 5; i++)
            push_candidate(20'(10 + i), 32'(50 - 10 * i), 1'b0);
        settle_block();
        write_register(kndsel_pkg::REG_KEEP_COUNT, 32'd3);
        write_register(kndsel_pkg::REG_INITIAL_BOUND, 32'h1234);
        push_candidate(20'd20, 32'd35, 1'b0);
        push_candidate(20'd21, 32'd45, 1'b1);
    endtask

    // bound rewritten with an empty store loads at once
    task automatic test_bound_written_mid_query();
        settle_block();
        write_register(kndsel_pkg::REG_INITIAL_BOUND, 32'd100);
        push_candidate(20'd30, 32'd200, 1'b0);
        settle_block();
        write_register(kndsel_pkg::REG_INITIAL_BOUND, 32'd300);
        push_candidate(20'd31, 32'd250, 1'b1);
    endtask

    // random queries under one register setting
    task automatic test_random_queries(logic [kndsel_pkg::DIST_W-1:0] bound,
                                       logic [kndsel_pkg::KEEP_W-1:0] keep,
                                       int unsigned budget, bit calm);
        int unsigned                      sent;
        int unsigned                      len;
        int unsigned                      limit;
        logic [kndsel_pkg::CAND_ID_W-1:0] rid;
        settle_block();
        write_register(kndsel_pkg::REG_INITIAL_BOUND, bound);
        write_register(kndsel_pkg::REG_KEEP_COUNT, kndsel_pkg::CFG_DATA_W'(keep));
        steady = calm;
        limit  = keep_limit();
        sent   = 0;
        while (sent < budget)
        begin
            // mostly short queries, sometimes enough to fill and replace
            if ($urandom_range(0, 5) == 0)
                len = $urandom_range(limit + 8, limit);
            else
                len = $urandom_range(10, 1);
            for (int unsigned k = 0; k < len; k++)
            begin
                rid = kndsel_pkg::CAND_ID_W'($urandom());
                push_candidate(rid, pick_distance(bound), k == len - 1);
            end
            sent += len;
            // hold off until every kept entry has drained
            if ($urandom_range(0, 3) == 0)
                settle_block();
        end
        steady = 1'b0;
    endtask

    // stimulus sequence
    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cand_id      = '0;
        cand_dist    = '0;
        query_end    = 1'b0;
        out_stall    = 1'b0;
        held_count   = 0;
        start_radius = kndsel_pkg::INITIAL_BOUND_RST;
        radius       = kndsel_pkg::INITIAL_BOUND_RST;
        keep_setting = kndsel_pkg::KEEP_COUNT_RST;
        error_count  = 0;
        steady       = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_query();
        test_empty_query();
        test_equal_distances();
        test_single_keep();
        test_keep_lowered_mid_query();
        test_bound_written_mid_query();
        test_random_queries($urandom(), 6'd4, 12, 1'b0);
        test_random_queries('1, 6'd63, 12, 1'b0);
        test_random_queries('0, 6'd1, 12, 1'b0);
        test_random_queries($urandom_range(100000, 1000), 6'd0, 12, 1'b1);
        test_random_queries($urandom(), 6'd7, 12, 1'b0);
        test_random_queries('1, 6'd32, 12, 1'b0);

        settle_block();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
